FILE: src/ervad_pkg.sv
package ervad_pkg;

  // configuration register indexes
  localparam logic [2:0] CfgWindow    = 3'd0;
  localparam logic [2:0] CfgLast      = 3'd1;
  localparam logic [2:0] CfgHpfEnable = 3'd2;
  localparam logic [2:0] CfgHpfAlpha  = 3'd3;
  localparam logic [2:0] CfgThreshold = 3'd4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CntW     = 15;
  localparam int unsigned CntMax   = 32767;
  localparam int unsigned SumW     = 30;
  localparam int unsigned CoefW    = 16;

  // products of the final compare
  localparam int unsigned LhsW = SumW + CntW;          // tail sum times window length
  localparam int unsigned TlW  = CoefW + CntW;         // threshold times tail length
  localparam int unsigned RhsW = TlW + SumW;           // threshold * tail length * total
  localparam int unsigned ThrFracW = 12;               // Q4.12 threshold

  localparam logic [CntW-1:0]  RstWindow    = 15'd16000;
  localparam logic [CntW-1:0]  RstLast      = 15'd3200;
  localparam logic             RstHpfEnable = 1'b1;
  localparam logic [CoefW-1:0] RstHpfAlpha  = 16'd63060;
  localparam logic [CoefW-1:0] RstThreshold = 16'd2458;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef struct packed {
    logic [CntW-1:0]  window_samples;
    logic [CntW-1:0]  last_samples;
    logic             hpf_enable;
    logic [CoefW-1:0] hpf_alpha;
    logic [CoefW-1:0] vad_threshold;
  } cfg_t;

  typedef struct packed {
    logic take;      // capture the incoming item and its filter product
    logic acc;       // round, saturate and accumulate
    logic mul_lhs;   // tail sum times window length
    logic mul_tl;    // threshold times tail length
    logic mul_rhs;   // previous product times total sum
    logic finish;    // compare, load result, restart window
  } dp_cmd_t;

  typedef struct packed {
    logic win_end;
  } dp_sts_t;

endpackage

FILE: src/energy_ratio_vad_unit.sv
// energy-ratio voice activity detector. one signed audio sample is taken per item; an
// optional one-pole high-pass filter runs first (the first sample of a window passes
// through), and the absolute filtered values are summed over the whole window and over
// its trailing last_samples samples, both saturating at 2^30 - 1. on the closing sample
// of a window one result item is produced: voice_quiet_tail is set when the recent mean
// is at most vad_threshold (Q4.12) times the overall mean, tested by cross-multiplication,
// and window_too_short forces it low when the tail is not shorter than the window. every
// sample goes through the filter multiply in the accept cycle, then through rounding,
// saturation and accumulation, because each filter input needs the previous output. the
// closing sample of a window also runs the product chain of the compare, and then waits
// until the result register can take its result. a finished result sits in its own
// register, so the next window's first sample is taken while the result still waits.
// window_samples of 0 acts as 1, and values above WINDOW_MAX act as WINDOW_MAX. writes to
// unused register indexes are ignored.
module energy_ratio_vad_unit
  import ervad_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = 16384,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [CfgIdxW-1:0]            cfg_idx_i,
  input  logic [CfgDataW-1:0]           cfg_wdata_i,
  // sample items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  // decision items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          voice_quiet_tail_o,
  output logic                          window_too_short_o,
  output logic [SumW-1:0]               energy_total_o,
  output logic [SumW-1:0]               energy_recent_o
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // register file
  ervad_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sequencing of filter, accumulate and compare steps
  ervad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // filter, energy sums and ratio compare
  ervad_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .sample_i           (sample_i),
    .voice_quiet_tail_o (voice_quiet_tail_o),
    .window_too_short_o (window_too_short_o),
    .energy_total_o     (energy_total_o),
    .energy_recent_o    (energy_recent_o)
  );

endmodule

FILE: src/ervad_cfg.sv
module ervad_cfg
  import ervad_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindow:    cfg_d.window_samples = cfg_wdata_i[CntW-1:0];
        CfgLast:      cfg_d.last_samples   = cfg_wdata_i[CntW-1:0];
        CfgHpfEnable: cfg_d.hpf_enable     = cfg_wdata_i[0];
        CfgHpfAlpha:  cfg_d.hpf_alpha      = cfg_wdata_i[CoefW-1:0];
        CfgThreshold: cfg_d.vad_threshold  = cfg_wdata_i[CoefW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_samples <= RstWindow;
      cfg_q.last_samples   <= RstLast;
      cfg_q.hpf_enable     <= RstHpfEnable;
      cfg_q.hpf_alpha      <= RstHpfAlpha;
      cfg_q.vad_threshold  <= RstThreshold;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/ervad_ctrl.sv
module ervad_ctrl
  import ervad_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StAcc    = 3'd1;
  localparam logic [2:0] StMulLhs = 3'd2;
  localparam logic [2:0] StMulTl  = 3'd3;
  localparam logic [2:0] StMulRhs = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = StAcc;
        end
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.win_end ? StMulLhs : StIdle;
      end
      StMulLhs: begin
        cmd_o.mul_lhs = 1'b1;
        state_d       = StMulTl;
      end
      StMulTl: begin
        cmd_o.mul_tl = 1'b1;
        state_d      = StMulRhs;
      end
      StMulRhs: begin
        cmd_o.mul_rhs = 1'b1;
        state_d       = StDone;
      end
      StDone: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

FILE: src/ervad_dp.sv
module ervad_dp
  import ervad_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = 16384,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  dp_cmd_t                       cmd_i,
  output dp_sts_t                       sts_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          voice_quiet_tail_o,
  output logic                          window_too_short_o,
  output logic [SumW-1:0]               energy_total_o,
  output logic [SumW-1:0]               energy_recent_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned DW = SB + 2;         // filter difference
  localparam int unsigned PW = SB + 19;        // coefficient times difference
  localparam int unsigned RW = PW - 16;        // rounded magnitude
  localparam int unsigned AW = SumW + 1;       // sum with carry
  localparam int unsigned NCap = (WINDOW_MAX > CntMax) ? CntMax : WINDOW_MAX;
  localparam logic [CntW-1:0] NCapV = NCap[CntW-1:0];
  localparam logic [RW-1:0] FMax = RW'((64'd1 << SB) - 64'd1);
  localparam logic [PW-1:0] RndHalf = PW'(32768);

  // window state
  logic signed [SB-1:0] prev_q;
  logic signed [SB:0]   fo_q;
  logic [SumW-1:0]      sum_all_q, sum_tail_q;
  logic [CntW-1:0]      idx_q;

  // per-item and compare registers
  logic signed [SB-1:0] x_q;
  logic                 byp_q;
  logic signed [PW-1:0] p_q;
  logic                 short_q;
  logic [LhsW-1:0]      lhs_q;
  logic [TlW-1:0]       tl_q;
  logic [RhsW-1:0]      rhs_q;

  logic                 quiet_q, short_out_q;
  logic [SumW-1:0]      tot_q, rec_q;

  logic [CntW-1:0]      n;
  logic                 too_short;
  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic                 p_neg;
  logic [PW-1:0]        pabs, prnd;
  logic [RW-1:0]        r;
  logic [SB-1:0]        fmag, xmag, mag;
  logic signed [SB:0]   y;
  logic [AW-1:0]        all_sum, tail_sum;
  logic [SumW-1:0]      all_sat, tail_sat;
  logic                 tail_in;
  logic [RhsW-1:0]      lhs_ext;
  logic                 quiet;

  // effective window length
  always_comb begin
    if (cfg_i.window_samples == '0) begin
      n = CntW'(1);
    end else if (cfg_i.window_samples > NCapV) begin
      n = NCapV;
    end else begin
      n = cfg_i.window_samples;
    end
  end

  assign too_short = cfg_i.last_samples >= n;

  // high-pass difference and coefficient product
  assign diff = DW'(fo_q) + DW'(sample_i) - DW'(prev_q);
  assign prod = PW'($signed({1'b0, cfg_i.hpf_alpha})) * PW'(diff);

  // round half away from zero, then saturate
  assign p_neg = p_q[PW-1];
  assign pabs  = p_neg ? (~p_q + PW'(1)) : p_q;
  assign prnd  = pabs + RndHalf;
  assign r     = prnd[PW-1:16];
  assign fmag  = (r > FMax) ? FMax[SB-1:0] : r[SB-1:0];
  assign xmag  = x_q[SB-1] ? (~x_q + SB'(1)) : x_q;
  assign mag   = byp_q ? xmag : fmag;

  always_comb begin
    if (byp_q) begin
      y = (SB+1)'(x_q);
    end else if (p_neg) begin
      y = -$signed({1'b0, fmag});
    end else begin
      y = $signed({1'b0, fmag});
    end
  end

  // saturating energy sums
  assign all_sum  = {1'b0, sum_all_q} + AW'(mag);
  assign tail_sum = {1'b0, sum_tail_q} + AW'(mag);
  assign all_sat  = all_sum[SumW] ? SumMax : all_sum[SumW-1:0];
  assign tail_sat = tail_sum[SumW] ? SumMax : tail_sum[SumW-1:0];
  assign tail_in  = too_short || (idx_q >= (n - cfg_i.last_samples));

  assign sts_o.win_end = ({1'b0, idx_q} + (CntW+1)'(1)) >= {1'b0, n};

  // recent * n * 4096 against threshold * total * last
  assign lhs_ext = RhsW'({lhs_q, {ThrFracW{1'b0}}});
  assign quiet   = !short_q && (lhs_ext <= rhs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      fo_q       <= '0;
      sum_all_q  <= '0;
      sum_tail_q <= '0;
      idx_q      <= '0;
    end else if (cmd_i.finish) begin
      prev_q     <= '0;
      fo_q       <= '0;
      sum_all_q  <= '0;
      sum_tail_q <= '0;
      idx_q      <= '0;
    end else if (cmd_i.acc) begin
      prev_q    <= x_q;
      fo_q      <= y;
      sum_all_q <= all_sat;
      if (tail_in) begin
        sum_tail_q <= tail_sat;
      end
      idx_q <= idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      x_q   <= sample_i;
      byp_q <= (idx_q == '0) || !cfg_i.hpf_enable;
      p_q   <= prod;
    end
    if (cmd_i.acc) begin
      short_q <= too_short;
    end
    if (cmd_i.mul_lhs) begin
      lhs_q <= LhsW'(sum_tail_q) * LhsW'(n);
    end
    if (cmd_i.mul_tl) begin
      tl_q <= TlW'(cfg_i.vad_threshold) * TlW'(cfg_i.last_samples);
    end
    if (cmd_i.mul_rhs) begin
      rhs_q <= RhsW'(tl_q) * RhsW'(sum_all_q);
    end
    if (cmd_i.finish) begin
      quiet_q     <= quiet;
      short_out_q <= short_q;
      tot_q       <= sum_all_q;
      rec_q       <= sum_tail_q;
    end
  end

  assign voice_quiet_tail_o = quiet_q;
  assign window_too_short_o = short_out_q;
  assign energy_total_o     = tot_q;
  assign energy_recent_o    = rec_q;

endmodule
